// ----- src/rgbgam_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbgam_pkg: shared types and constants for the rgb565 gamma block
// Holds request codes, curve selects, the channel widening tables and the
// rounding narrow function used on looked-up curve words.
// ----------------------------------------------------------------------------
package rgbgam_pkg;

  localparam int PIXEL_W      = 16;
  localparam int CURVE_W      = 16;
  localparam int CURVE_DEPTH  = 256;
  localparam int LEVEL_W      = 8;
  localparam int RED_W        = 5;
  localparam int GREEN_W      = 6;
  localparam int BLUE_W       = 5;

  // request codes
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_LOAD  = 1'b1;

  // curve selects, the fourth code loads nothing
  localparam logic [1:0] CURVE_RED   = 2'd0;
  localparam logic [1:0] CURVE_GREEN = 2'd1;
  localparam logic [1:0] CURVE_BLUE  = 2'd2;

  localparam int NARROW_BIAS = 32767;
  localparam int FULL_SCALE  = 65535;

  typedef logic [31:0][LEVEL_W-1:0] widen5_lut_t;
  typedef logic [63:0][LEVEL_W-1:0] widen6_lut_t;

  typedef struct packed {
    logic                 apply;
    logic [PIXEL_W-1:0]   pixel;
  } pix_meta_t;

  typedef struct packed {
    logic [CURVE_W-1:0] red;
    logic [CURVE_W-1:0] green;
    logic [CURVE_W-1:0] blue;
  } curve_words_t;

  function automatic widen5_lut_t build_widen5();
    widen5_lut_t lut;
    for (int i = 0; i < 32; i++) begin
      lut[i] = LEVEL_W'((i * 255 + 15) / 31);
    end
    return lut;
  endfunction

  function automatic widen6_lut_t build_widen6();
    widen6_lut_t lut;
    for (int i = 0; i < 64; i++) begin
      lut[i] = LEVEL_W'((i * 255 + 31) / 63);
    end
    return lut;
  endfunction

  localparam widen5_lut_t WIDEN5_LUT = build_widen5();
  localparam widen6_lut_t WIDEN6_LUT = build_widen6();

  // (c*maxv + 32767) / 65535 with q0 = x >> 16 and one correction step,
  // the remainder estimate stays below twice the divisor
  function automatic logic [5:0] narrow_level(input logic [CURVE_W-1:0] c,
                                              input logic [5:0] maxv);
    logic [21:0] x;
    logic [5:0]  q0;
    logic [16:0] r;
    x  = 22'(c) * 22'(maxv) + 22'(NARROW_BIAS);
    q0 = x[21:16];
    r  = 17'(x[15:0]) + 17'(q0);
    return (r >= 17'(FULL_SCALE)) ? q0 + 6'd1 : q0;
  endfunction

endpackage

// ----- src/rgbgam_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbgam_if: request and pixel channels of the rgb565 gamma block
// Valid/ready channels; a transaction happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface rgbgam_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] pixel_in;
  logic [1:0]  curve_select;
  logic [7:0]  curve_index;
  logic [15:0] curve_value;
  logic        load_last;

  modport source (output valid, req_type, pixel_in, curve_select, curve_index,
                  curve_value, load_last, input ready);
  modport sink   (input valid, req_type, pixel_in, curve_select, curve_index,
                  curve_value, load_last, output ready);
endinterface

interface rgbgam_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_out;

  modport source (output valid, pixel_out, input ready);
  modport sink   (input valid, pixel_out, output ready);
endinterface

// ----- src/rgbgam_curve_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbgam_curve_ram: single-port-write, single-port-read curve memory
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
module rgbgam_curve_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/rgbgam_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbgam_lookup: request intake, curve storage and curve lookup stage
// Stores curve words, widens each channel and reads the three curves.
// ----------------------------------------------------------------------------
module rgbgam_lookup (
  input  logic                       clk,
  input  logic                       rst,
  rgbgam_req_if.sink                 pixel_req,
  output logic                       stage_valid,
  input  logic                       stage_ready,
  output rgbgam_pkg::pix_meta_t      stage_meta,
  output rgbgam_pkg::curve_words_t   stage_words
);
  import rgbgam_pkg::*;

  logic       accept;
  logic       pix_accept;
  logic       load_accept;
  logic       curves_valid;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;

  assign pixel_req.ready = !stage_valid || stage_ready;
  assign accept      = pixel_req.valid && pixel_req.ready;
  assign pix_accept  = accept && (pixel_req.req_type == REQ_PIXEL);
  assign load_accept = accept && (pixel_req.req_type == REQ_LOAD);

  assign red_level   = WIDEN5_LUT[pixel_req.pixel_in[15:11]];
  assign green_level = WIDEN6_LUT[pixel_req.pixel_in[10:5]];
  assign blue_level  = WIDEN5_LUT[pixel_req.pixel_in[4:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      curves_valid <= 1'b0;
    end else begin
      if (pixel_req.ready) begin
        stage_valid <= pix_accept;
      end
      if (load_accept) begin
        curves_valid <= pixel_req.load_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      stage_meta.pixel <= pixel_req.pixel_in;
      stage_meta.apply <= curves_valid;
    end
  end

  rgbgam_curve_ram #(.WIDTH(CURVE_W), .DEPTH(CURVE_DEPTH)) u_red_ram (
    .clk   (clk),
    .we    (load_accept && (pixel_req.curve_select == CURVE_RED)),
    .waddr (pixel_req.curve_index),
    .wdata (pixel_req.curve_value),
    .re    (pix_accept),
    .raddr (red_level),
    .rdata (stage_words.red)
  );

  rgbgam_curve_ram #(.WIDTH(CURVE_W), .DEPTH(CURVE_DEPTH)) u_green_ram (
    .clk   (clk),
    .we    (load_accept && (pixel_req.curve_select == CURVE_GREEN)),
    .waddr (pixel_req.curve_index),
    .wdata (pixel_req.curve_value),
    .re    (pix_accept),
    .raddr (green_level),
    .rdata (stage_words.green)
  );

  rgbgam_curve_ram #(.WIDTH(CURVE_W), .DEPTH(CURVE_DEPTH)) u_blue_ram (
    .clk   (clk),
    .we    (load_accept && (pixel_req.curve_select == CURVE_BLUE)),
    .waddr (pixel_req.curve_index),
    .wdata (pixel_req.curve_value),
    .re    (pix_accept),
    .raddr (blue_level),
    .rdata (stage_words.blue)
  );

endmodule

// ----- src/rgbgam_output.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbgam_output: curve word narrowing and output register
// Rounds each curve word back to 5/6/5 bits and holds the result pixel.
// ----------------------------------------------------------------------------
module rgbgam_output (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       stage_valid,
  output logic                       stage_ready,
  input  rgbgam_pkg::pix_meta_t      stage_meta,
  input  rgbgam_pkg::curve_words_t   stage_words,
  rgbgam_pix_if.source               pixel_rsp
);
  import rgbgam_pkg::*;

  logic [5:0]          red_out;
  logic [5:0]          green_out;
  logic [5:0]          blue_out;
  logic [PIXEL_W-1:0]  corrected;
  logic [PIXEL_W-1:0]  pixel_out_next;

  assign red_out   = narrow_level(stage_words.red, 6'd31);
  assign green_out = narrow_level(stage_words.green, 6'd63);
  assign blue_out  = narrow_level(stage_words.blue, 6'd31);

  assign corrected      = {red_out[4:0], green_out, blue_out[4:0]};
  assign pixel_out_next = stage_meta.apply ? corrected : stage_meta.pixel;

  assign stage_ready = !pixel_rsp.valid || pixel_rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_rsp.valid <= 1'b0;
    end else if (stage_ready) begin
      pixel_rsp.valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid && stage_ready) begin
      pixel_rsp.pixel_out <= pixel_out_next;
    end
  end

endmodule

// ----- src/rgb565_gamma_correction_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_gamma_correction_top: per-channel gamma correction of rgb565 pixels
// Widens each channel to 8 bits, looks up its 16-bit curve, rounds it back.
// ----------------------------------------------------------------------------
// pixel_req carries two kinds of transaction: a curve word load, which writes
// one entry of the red, green or blue curve and gives no result, and a pixel,
// which gives exactly one transaction on pixel_rsp. A load flagged last turns
// correction on; any other load turns it off until the next last load, and
// while it is off pixels come out unchanged.
// A pixel transaction registers the curve memory reads in the lookup stage,
// and the narrowed pixel is then loaded into the output register. Throughput
// is one transaction per cycle while pixel_rsp does not stall, set by the
// single read port of each curve memory.
// A load may be followed by a pixel on the next cycle and that pixel already
// sees the new word.
// Reset clears the pipeline and the correction enable; curve memories keep
// whatever they held and must be loaded before correction is turned on.
// When pixel_rsp stalls, the result and one more pixel in the lookup stage
// are held, and pixel_req.ready drops only once both are occupied.
// ----------------------------------------------------------------------------
module rgb565_gamma_correction_top (
  input  logic          clk,
  input  logic          rst,
  rgbgam_req_if.sink    pixel_req,
  rgbgam_pix_if.source  pixel_rsp
);
  import rgbgam_pkg::*;

  logic         stage_valid;
  logic         stage_ready;
  pix_meta_t    stage_meta;
  curve_words_t stage_words;

  rgbgam_lookup u_lookup (
    .clk         (clk),
    .rst         (rst),
    .pixel_req   (pixel_req),
    .stage_valid (stage_valid),
    .stage_ready (stage_ready),
    .stage_meta  (stage_meta),
    .stage_words (stage_words)
  );

  rgbgam_output u_output (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_ready (stage_ready),
    .stage_meta  (stage_meta),
    .stage_words (stage_words),
    .pixel_rsp   (pixel_rsp)
  );

endmodule

// ----- src/rgbgam_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbgam_checker: port-level checks for the rgb565 gamma block
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module rgbgam_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pixel
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its pixel
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_pixel))
    else $error("result pixel changed while stalled");

  // reset empties the pipeline
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // the request side only backs up behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !out_ready) |-> in_ready)
    else $error("request not ready while result side flows");

  // a result never appears unless a request was offered, or a result was valid, before it
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid, 2) || $past(out_valid, 2))
    else $error("result without a pixel transaction");

endmodule

bind rgb565_gamma_correction_top rgbgam_checker u_rgbgam_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixel_req.valid),
  .in_ready  (pixel_req.ready),
  .out_valid (pixel_rsp.valid),
  .out_ready (pixel_rsp.ready),
  .out_pixel (pixel_rsp.pixel_out)
);
